// ===== hw/rtl/srmq_pkg.sv =====
// ----------------------------------------------------------------------------
// srmq_pkg
// Shared constants, types and helpers for the sparse table range-max unit.
// ----------------------------------------------------------------------------
package srmq_pkg;

    localparam int CAPACITY   = 1024;
    localparam int LEVELS     = 11;
    localparam int DATA_WIDTH = 32;

    // fixed field widths of the request and response channels
    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int QIDX_W = 11;
    localparam int STAT_W = 2;
    localparam int OCNT_W = 11;

    localparam int DEPTH  = LEVELS * CAPACITY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int CMP_W  = ((CNT_W > QIDX_W) ? CNT_W : QIDX_W) + 1;
    localparam int SPAN_W = ((LEVELS > CMP_W) ? LEVELS : CMP_W) + 1;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [ADDR_W-1:0]            addr_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [LVL_W-1:0]             lvl_t;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APP_WR0,
        S_APP_MAX,
        S_QRY_RD1,
        S_QRY_RD2,
        S_QRY_CMP,
        S_DONE
    } state_t;

    // table write port
    typedef struct packed {
        logic  en;
        addr_t addr;
        data_t data;
    } ram_wr_t;

    // level-major layout, 1-based position
    function automatic addr_t tbl_addr(lvl_t lvl, cnt_t pos);
        return ADDR_W'(int'(lvl) * CAPACITY + int'(pos) - 1);
    endfunction

    // priority encoder, capped at the top level
    function automatic lvl_t floor_log2(logic [QIDX_W-1:0] len);
        lvl_t j;
        j = '0;
        for (int b = 1; b < QIDX_W; b++)
        begin
            if (len[b])
            begin
                j = LVL_W'(b);
            end
        end
        if (int'(j) > LEVELS - 1)
        begin
            j = LVL_W'(LEVELS - 1);
        end
        return j;
    endfunction

endpackage

// ===== hw/rtl/srmq_req_if.sv =====
// ----------------------------------------------------------------------------
// srmq_req_if
// Request channel: append, query or clear.
// ----------------------------------------------------------------------------
interface srmq_req_if
    import srmq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [VAL_W-1:0]  element_value;
    logic [QIDX_W-1:0]        query_left;
    logic [QIDX_W-1:0]        query_right;

    modport source (output valid, op, element_value, query_left, query_right,
                    input ready);
    modport sink   (input valid, op, element_value, query_left, query_right,
                    output ready);
endinterface

// ===== hw/rtl/srmq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// srmq_rsp_if
// Response channel: one response per request.
// ----------------------------------------------------------------------------
interface srmq_rsp_if
    import srmq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  max_value;
    logic [STAT_W-1:0]        status;
    logic [OCNT_W-1:0]        loaded_count;

    modport source (output valid, max_value, status, loaded_count, input ready);
    modport sink   (input valid, max_value, status, loaded_count, output ready);
endinterface

// ===== hw/rtl/sparse_table_range_max_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_table_range_max_unit
// Range-maximum engine over an incrementally built sparse table.
// ----------------------------------------------------------------------------
// Usage
//   req carries one request: op 0 appends element_value at the next index,
//   op 1 asks for the maximum over [query_left, query_right] (1-based),
//   op 2 clears the table. Unused op 3 gets max_value 0, status ok and the
//   current count.
//   rsp returns one response per request: max_value, status, loaded_count.
//   Requests are taken one at a time; req.ready is high only when idle.
// Sequence (request accept to rsp.valid, output register free)
//   append : level 0 write, then k = min(floor(log2(n)), LEVELS-1) levels filled
//            after level 0, one per cycle, then the done state
//   query  : two table reads and one compare, then the done state
//   clear, op 3, rejected or empty requests : straight to the done state
//   The next request can be taken in the cycle after the response is loaded.
//   Throughput is set by the single table port pair and the shared max
//   unit: every filled level costs one read, one compare and one write.
// Reset
//   Clears the state, element count and response valid flag. Table contents are
//   left as they are; an entry is always written before it can be read.
// Back-pressure
//   A finished response waits in the output register; while rsp.ready is
//   low the next request may still be taken, and its own response waits in
//   the done state until the register frees up.
// ----------------------------------------------------------------------------
module sparse_table_range_max_unit
    import srmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    srmq_req_if.sink  req,
    srmq_rsp_if.source rsp
);

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    lvl_t    lvl_reg, lvl_next;
    cnt_t    l_reg, l_next;
    cnt_t    pos2_reg, pos2_next;
    data_t   prev_reg, prev_next;
    data_t   res_reg, res_next;
    status_t status_reg, status_next;

    logic                out_valid_reg, out_valid_next;
    data_t               out_max_reg, out_max_next;
    status_t             out_status_reg, out_status_next;
    logic [OCNT_W-1:0]   out_count_reg, out_count_next;

    ram_wr_t wr;
    addr_t   rd_addr;
    data_t   rd_data;
    data_t   mx;

    // append level walk
    lvl_t              nxt_lvl;
    logic [SPAN_W-1:0] nxt_span, cur_span, n_ext;
    logic              cont;
    cnt_t              rd_pos, wr_pos;

    // query decode
    logic [CMP_W-1:0]  q_l, q_r, q_cnt, q_second;
    logic [QIDX_W-1:0] q_len;
    lvl_t              q_lvl;

    srmq_table_ram u_ram
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // operands are the same in both uses: fresh read data against the held one
    srmq_max_unit u_max
    (
        .a (rd_data),
        .b (prev_reg),
        .y (mx)
    );

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid        = out_valid_reg;
    assign rsp.max_value    = VAL_W'(out_max_reg);
    assign rsp.status       = out_status_reg;
    assign rsp.loaded_count = out_count_reg;

    always_comb
    begin
        // next level to fill; the window ending at n starts at n - 2^lvl + 1
        nxt_lvl  = (state_reg == S_APP_WR0) ? LVL_W'(1) : lvl_reg + LVL_W'(1);
        n_ext    = SPAN_W'(count_reg);
        nxt_span = SPAN_W'(1) << nxt_lvl;
        cur_span = SPAN_W'(1) << lvl_reg;
        cont     = (int'(nxt_lvl) < LEVELS) && (nxt_span <= n_ext);
        rd_pos   = CNT_W'(n_ext + SPAN_W'(1) - nxt_span);
        wr_pos   = CNT_W'(n_ext + SPAN_W'(1) - cur_span);

        q_l      = CMP_W'(req.query_left);
        q_r      = CMP_W'(req.query_right);
        q_cnt    = CMP_W'(count_reg);
        q_len    = QIDX_W'(q_r - q_l + CMP_W'(1));
        q_lvl    = floor_log2(q_len);
        q_second = q_r + CMP_W'(1) - (CMP_W'(1) << q_lvl);
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        lvl_next        = lvl_reg;
        l_next          = l_reg;
        pos2_next       = pos2_reg;
        prev_next       = prev_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_max_next    = out_max_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        wr              = '0;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (req.op)
                        OP_APPEND:
                        begin
                            if (int'(count_reg) >= CAPACITY)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                prev_next  = DATA_WIDTH'(req.element_value);
                                state_next = S_APP_WR0;
                            end
                        end
                        OP_QUERY:
                        begin
                            // empty range wins over the index check
                            if (q_l > q_r)
                            begin
                                status_next = ST_OK;
                            end
                            else if (q_l == '0 || q_r > q_cnt)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                l_next     = CNT_W'(q_l);
                                pos2_next  = CNT_W'(q_second);
                                lvl_next   = q_lvl;
                                state_next = S_QRY_RD1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_APP_WR0:
            begin
                wr.en    = 1'b1;
                wr.addr  = tbl_addr('0, count_reg);
                wr.data  = prev_reg;
                rd_addr  = tbl_addr(nxt_lvl - LVL_W'(1), rd_pos);
                lvl_next = nxt_lvl;
                state_next = cont ? S_APP_MAX : S_DONE;
            end

            S_APP_MAX:
            begin
                // right half was the previous level's write, held in prev_reg
                wr.en     = 1'b1;
                wr.addr   = tbl_addr(lvl_reg, wr_pos);
                wr.data   = mx;
                prev_next = mx;
                rd_addr   = tbl_addr(nxt_lvl - LVL_W'(1), rd_pos);
                if (cont)
                begin
                    lvl_next = nxt_lvl;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_QRY_RD1:
            begin
                rd_addr    = tbl_addr(lvl_reg, l_reg);
                state_next = S_QRY_RD2;
            end

            S_QRY_RD2:
            begin
                rd_addr    = tbl_addr(lvl_reg, pos2_reg);
                prev_next  = rd_data;
                state_next = S_QRY_CMP;
            end

            S_QRY_CMP:
            begin
                res_next   = mx;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_max_next    = res_reg;
                    out_status_next = status_reg;
                    out_count_next  = OCNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg        <= lvl_next;
        l_reg          <= l_next;
        pos2_reg       <= pos2_next;
        prev_reg       <= prev_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        out_max_reg    <= out_max_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= CAPACITY)
        else $error("element count above capacity");

    a_wr_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_APP_WR0 || state_reg == S_APP_MAX))
        else $error("table write outside append walk");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear did not reset count");

    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APP_MAX) |-> (lvl_reg >= LVL_W'(1) &&
                                      int'(lvl_reg) <= LEVELS - 1))
        else $error("level walk out of range");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> ($past(state_reg) == S_DONE))
        else $error("response loaded outside done state");

endmodule

// ===== hw/rtl/srmq_table_ram.sv =====
// ----------------------------------------------------------------------------
// srmq_table_ram
// Sparse table store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srmq_table_ram
    import srmq_pkg::*;
(
    input  logic    clk,
    input  ram_wr_t wr,
    input  addr_t   rd_addr,
    output data_t   rd_data
);

    data_t mem [DEPTH];
    data_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/srmq_max_unit.sv =====
// ----------------------------------------------------------------------------
// srmq_max_unit
// Shared signed maximum, used once per level step and once per query.
// ----------------------------------------------------------------------------
module srmq_max_unit
    import srmq_pkg::*;
(
    input  data_t a,
    input  data_t b,
    output data_t y
);

    // ties keep a
    assign y = (a >= b) ? a : b;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for sparse_table_range_max_unit. Requests go in
// through a random-gap sender and responses come out through a sink with
// random back-pressure. Every accepted request is run through a local sparse
// table, and the expected response is queued for comparison in order.
// ----------------------------------------------------------------------------
module tb;
    import srmq_pkg::*;

    // op code 3 has no function; the unit answers max_value 0, status ok
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int IDLE_MAX        = 16;    // longest gap or stall per request
    localparam int RANDOM_REQUESTS = 100;
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES   = 20;    // margin for the longest append
    localparam int MAX_REPORTS     = 40;
    localparam int QIDX_MAX        = (1 << QIDX_W) - 1;

    typedef struct {
        data_t             max_value;
        status_t           status;
        logic [OCNT_W-1:0] loaded_count;
    } range_answer_t;

    logic clk;
    logic rst_n;

    srmq_req_if req ();
    srmq_rsp_if rsp ();

    sparse_table_range_max_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // ------------------------------------------------------------------------
    // Local copy of the table: sparse_levels[j][p-1] holds the maximum of the
    // 2^j elements starting at 1-based position p.
    // ------------------------------------------------------------------------
    data_t         sparse_levels [LEVELS][CAPACITY];
    int unsigned   elements_held = 0;
    range_answer_t awaited_answers [$];

    int req_idle_max = IDLE_MAX;
    int rsp_idle_max = IDLE_MAX;
    int mismatches   = 0;

    // what the run went through, for the closing summary
    int appends_taken        = 0;
    int appends_refused      = 0;
    int queries_answered     = 0;
    int queries_out_of_range = 0;
    int queries_empty        = 0;
    int clears_seen          = 0;
    int unused_ops           = 0;
    int responses_checked    = 0;

    // ------------------------------------------------------------------------
    // Clock (reset is driven in the main sequence)
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic data_t larger_of(data_t a, data_t b);
        return (a > b) ? a : b;
    endfunction

    // ------------------------------------------------------------------------
    // Applies one request to the local table and returns the response the
    // unit owes for it.
    // ------------------------------------------------------------------------
    function automatic range_answer_t evaluate_request(
        logic [OP_W-1:0]   op,
        data_t             value,
        logic [QIDX_W-1:0] first_idx,
        logic [QIDX_W-1:0] last_idx
    );
        range_answer_t ans;
        int unsigned   lvl;
        int unsigned   span;
        int unsigned   start;
        int unsigned   len;
        int unsigned   tail;
        ans.max_value = '0;
        ans.status    = ST_OK;
        case (op)
            OP_APPEND:
            begin
                if (elements_held >= CAPACITY)
                begin
                    ans.status = ST_FULL;
                    appends_refused++;
                end
                else
                begin
                    elements_held++;
                    appends_taken++;
                    sparse_levels[0][elements_held - 1] = value;
                    // refresh every window that now ends at the new element
                    for (lvl = 1; lvl < LEVELS && (1 << lvl) <= elements_held; lvl++)
                    begin
                        span  = 1 << lvl;
                        start = elements_held - span;
                        sparse_levels[lvl][start] =
                            larger_of(sparse_levels[lvl - 1][start],
                                      sparse_levels[lvl - 1][start + span / 2]);
                    end
                end
            end
            OP_QUERY:
            begin
                // empty range wins over the index check
                if (first_idx > last_idx)
                begin
                    queries_empty++;
                end
                else if (first_idx == 0 || last_idx > elements_held)
                begin
                    ans.status = ST_RANGE;
                    queries_out_of_range++;
                end
                else
                begin
                    len = int'(last_idx) - int'(first_idx) + 1;
                    lvl = 0;
                    while ((2 << lvl) <= len)
                    begin
                        lvl++;
                    end
                    if (lvl > LEVELS - 1)
                    begin
                        lvl = LEVELS - 1;
                    end
                    // two overlapping windows: one from the left end, one to the right end
                    tail = int'(last_idx) + 1 - (1 << lvl);
                    ans.max_value = larger_of(sparse_levels[lvl][int'(first_idx) - 1],
                                              sparse_levels[lvl][tail - 1]);
                    queries_answered++;
                end
            end
            OP_CLEAR:
            begin
                elements_held = 0;
                clears_seen++;
            end
            default:
            begin
                unused_ops++;
            end
        endcase
        ans.loaded_count = OCNT_W'(elements_held);
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. valid is left high after the handshake so that a request
    // with no gap follows straight on; whoever stops sending lowers it.
    // ------------------------------------------------------------------------
    task automatic send_request(
        input logic [OP_W-1:0]   op,
        input data_t             value,
        input logic [QIDX_W-1:0] first_idx,
        input logic [QIDX_W-1:0] last_idx
    );
        int gap;
        gap = $urandom_range(0, req_idle_max);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.op            <= op;
        req.element_value <= value;
        req.query_left    <= first_idx;
        req.query_right   <= last_idx;
        @(posedge clk);
        while (req.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        awaited_answers.insert(awaited_answers.size(),
                               evaluate_request(op, value, first_idx, last_idx));
    endtask

    // unused fields carry noise so that the unit is seen to ignore them
    task automatic append_value(input data_t value);
        send_request(OP_APPEND, value, $urandom_range(0, QIDX_MAX), $urandom_range(0, QIDX_MAX));
    endtask

    task automatic query_range(input int unsigned first_idx, input int unsigned last_idx);
        send_request(OP_QUERY, $urandom, first_idx, last_idx);
    endtask

    // idle pattern for the next stretch: both sides, one side only, or none
    task automatic choose_idle_mode();
        case ($urandom_range(0, 3))
            0:
            begin
                req_idle_max = IDLE_MAX;
                rsp_idle_max = IDLE_MAX;
            end
            1:
            begin
                req_idle_max = 0;
                rsp_idle_max = IDLE_MAX;
            end
            2:
            begin
                req_idle_max = IDLE_MAX;
                rsp_idle_max = 0;
            end
            default:
            begin
                req_idle_max = 0;
                rsp_idle_max = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stall after each handshake, in-order compare.
    // ------------------------------------------------------------------------
    task automatic check_field(
        input string             field,
        input logic signed [63:0] want,
        input logic signed [63:0] got
    );
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        end
    endtask

    initial
    begin : response_sink
        int            stall_left;
        range_answer_t want;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                begin
                    responses_checked++;
                    if (awaited_answers.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%0t: response with no request outstanding, expected none, got max_value %0d status %0d loaded_count %0d",
                                     $time, rsp.max_value, rsp.status, rsp.loaded_count);
                        end
                    end
                    else
                    begin
                        want = awaited_answers.pop_front();
                        check_field("max_value", want.max_value, rsp.max_value);
                        check_field("status", want.status, rsp.status);
                        check_field("loaded_count", want.loaded_count, rsp.loaded_count);
                    end
                    stall_left = $urandom_range(0, rsp_idle_max);
                end
                if (stall_left > 0)
                begin
                    rsp.ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    rsp.ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: reset or any handshake on either side restarts the count.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req.valid === 1'b1 && req.ready === 1'b1)
                       || (rsp.valid === 1'b1 && rsp.ready === 1'b1))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("%0t: no request or response moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Corners on a small table: empty table, extreme values, single
    // elements, both index errors, empty range ahead of the index check,
    // clear and the unused op code.
    // ------------------------------------------------------------------------
    task automatic test_directed_corners();
        choose_idle_mode();
        query_range(1, 1);                          // nothing loaded yet
        query_range(3, 2);                          // empty range, empty table
        send_request(OP_UNUSED, '0, '0, '0);
        send_request(OP_CLEAR, '0, '0, '0);
        append_value(32'h7FFF_FFFF);
        append_value(32'h8000_0000);
        append_value(32'h0000_0000);
        append_value(32'hFFFF_FFFF);
        append_value(32'h0000_0001);
        query_range(1, 1);
        query_range(2, 2);
        query_range(1, 5);
        query_range(2, 5);
        query_range(3, 4);
        query_range(0, 3);                          // left index zero
        query_range(0, 0);
        query_range(2, 6);                          // right past the count
        query_range(QIDX_MAX, 0);                   // empty, top bits set
        query_range(1, QIDX_MAX);
        send_request(OP_CLEAR, $urandom, QIDX_MAX, QIDX_MAX);
        query_range(1, 1);                          // stale entries must not show
        append_value(32'hAAAA_5555);
        query_range(1, 1);
        send_request(OP_UNUSED, 32'hFFFF_FFFF, QIDX_MAX, QIDX_MAX);
    endtask

    // ------------------------------------------------------------------------
    // Load the whole table, with spot queries on the way up, then push past
    // capacity and query over the full span and the top level.
    // ------------------------------------------------------------------------
    task automatic test_fill_to_capacity();
        int unsigned first_idx;
        int unsigned last_idx;
        choose_idle_mode();
        send_request(OP_CLEAR, $urandom, '0, '0);
        for (int n = 1; n <= CAPACITY; n++)
        begin
            if (n % 128 == 0)
            begin
                choose_idle_mode();
            end
            append_value($urandom);
            if (n % 32 == 0)
            begin
                first_idx = $urandom_range(1, n);
                last_idx  = $urandom_range(first_idx, n);
                query_range(first_idx, last_idx);
            end
        end
        append_value(32'h7FFF_FFFF);                // refused: table full
        append_value(32'h8000_0000);
        query_range(1, CAPACITY);
        query_range(1, CAPACITY - 1);
        query_range(2, CAPACITY);
        query_range(CAPACITY / 2 + 1, CAPACITY);
        query_range(CAPACITY, CAPACITY);
        query_range(1, CAPACITY + 1);               // one past the end
        query_range(CAPACITY + 1, CAPACITY);        // empty
        send_request(OP_UNUSED, $urandom, '0, '0);
        send_request(OP_CLEAR, $urandom, $urandom_range(0, QIDX_MAX), $urandom_range(0, QIDX_MAX));
    endtask

    // ------------------------------------------------------------------------
    // Mostly appends and in-range queries so that several levels fill up,
    // with noise queries, empty ranges, rare clears and the odd unused code.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        int unsigned pick;
        int unsigned first_idx;
        int unsigned last_idx;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 25 == 0)
            begin
                choose_idle_mode();
            end
            pick      = $urandom_range(0, 99);
            first_idx = $urandom_range(0, QIDX_MAX);
            last_idx  = $urandom_range(0, QIDX_MAX);
            if (pick < 45)
            begin
                append_value($urandom);
            end
            else if (pick < 84 && elements_held != 0)
            begin
                first_idx = $urandom_range(1, elements_held);
                last_idx  = $urandom_range(first_idx, elements_held);
                query_range(first_idx, last_idx);
            end
            else if (pick < 91)
            begin
                query_range(first_idx, last_idx);   // anything the fields allow
            end
            else if (pick < 96)
            begin
                last_idx  = $urandom_range(0, QIDX_MAX - 1);
                first_idx = $urandom_range(last_idx + 1, QIDX_MAX);
                query_range(first_idx, last_idx);
            end
            else if (pick < 97)
            begin
                send_request(OP_CLEAR, $urandom, first_idx, last_idx);
            end
            else
            begin
                send_request(OP_UNUSED, $urandom, first_idx, last_idx);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n             <= 1'b0;
        req.valid         <= 1'b0;
        req.op            <= OP_APPEND;
        req.element_value <= '0;
        req.query_left    <= '0;
        req.query_right   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_fill_to_capacity();
        test_random_traffic();

        // last request has just been taken; stop offering it
        req.valid <= 1'b0;
        while (awaited_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d appends (%0d refused on a full table), %0d answered queries, %0d out of range, %0d empty ranges",
                 appends_taken, appends_refused, queries_answered, queries_out_of_range,
                 queries_empty);
        $display("plus %0d clears and %0d unused op codes; %0d responses compared, %0d mismatches",
                 clears_seen, unused_ops, responses_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
